// ===== rtl/iso_week_date_calc_defines.svh =====
// Assertion macros shared by the RTL files.
`ifndef ISO_WEEK_DATE_CALC_DEFINES_SVH
`define ISO_WEEK_DATE_CALC_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define IWD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define IWD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/iwd_pkg.sv =====
package iwd_pkg;

    // y / 100 == (y * 5243) >> 19 for every 14-bit y
    localparam logic [12:0] DIV100_MUL = 13'd5243;
    localparam int          DIV100_SHIFT = 19;
    localparam logic [13:0] PREV_OF_ZERO = 14'd399;

    typedef struct packed {
        logic        ok;
        logic        leap;
        logic        leap_prev;
        logic [4:0]  mlen;
        logic [8:0]  doy;
        logic [13:0] year;
        logic [7:0]  wsum;
        logic [7:0]  jsum;
    } t_s2;

    typedef struct packed {
        logic        ok;
        logic        leap;
        logic        leap_prev;
        logic [4:0]  mlen;
        logic [8:0]  doy;
        logic [13:0] year;
        logic [2:0]  wd;
        logic [2:0]  jan1;
    } t_s3;

    // s / 7 for s < 512: (s * 2341) >> 14
    function automatic logic [6:0] div7(input logic [8:0] s);
        logic [20:0] p;
        p = 21'(s) * 21'd2341;
        return p[20:14];
    endfunction

    function automatic logic [2:0] mod7(input logic [8:0] s);
        logic [6:0] q;
        logic [8:0] r;
        q = div7(s);
        r = s - 9'(q) * 9'd7;
        return r[2:0];
    endfunction

    // ISO weekday 1..7 from a weekday sum
    function automatic logic [2:0] iso_wd(input logic [7:0] s);
        logic [2:0] r;
        r = mod7({1'b0, s});
        return (r == 3'd0) ? 3'd7 : r;
    endfunction

    // y_lo: y mod 4, rem: y mod 100, q_lo: (y / 100) mod 4
    function automatic logic leap_of(input logic [1:0] y_lo, input logic [6:0] rem,
                                     input logic [1:0] q_lo);
        return (y_lo == 2'd0) && ((rem != 7'd0) || (q_lo == 2'd0));
    endfunction

    function automatic logic [2:0] month_anchor(input logic leap, input logic [3:0] m);
        logic [2:0] a;
        case (m)
            4'd1:    a = leap ? 3'd6 : 3'd0;
            4'd2:    a = leap ? 3'd2 : 3'd3;
            4'd3:    a = 3'd3;
            4'd4:    a = 3'd6;
            4'd5:    a = 3'd1;
            4'd6:    a = 3'd4;
            4'd7:    a = 3'd6;
            4'd8:    a = 3'd2;
            4'd9:    a = 3'd5;
            4'd10:   a = 3'd0;
            4'd11:   a = 3'd3;
            4'd12:   a = 3'd5;
            default: a = 3'd0;
        endcase
        return a;
    endfunction

    function automatic logic [8:0] days_before(input logic leap, input logic [3:0] m);
        logic [8:0] b;
        case (m)
            4'd1:    b = 9'd0;
            4'd2:    b = 9'd31;
            4'd3:    b = 9'd59;
            4'd4:    b = 9'd90;
            4'd5:    b = 9'd120;
            4'd6:    b = 9'd151;
            4'd7:    b = 9'd181;
            4'd8:    b = 9'd212;
            4'd9:    b = 9'd243;
            4'd10:   b = 9'd273;
            4'd11:   b = 9'd304;
            4'd12:   b = 9'd334;
            default: b = 9'd0;
        endcase
        if (leap && (m > 4'd2)) begin
            b = b + 9'd1;
        end
        return b;
    endfunction

    // common-year month length, 0 for a bad month
    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] l;
        case (m)
            4'd2:                       l = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:    l = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7,
            4'd8, 4'd10, 4'd12:         l = 5'd31;
            default:                    l = 5'd0;
        endcase
        return l;
    endfunction

endpackage

// ===== rtl/iwd_year.sv =====
`include "iso_week_date_calc_defines.svh"

module iwd_year (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [13:0]      i_year,
    input  logic [3:0]       i_month,
    input  logic [4:0]       i_day,
    output logic             o_valid,
    input  logic             i_ready,
    output iwd_pkg::t_s2     o_s2
);

    // stage A: reciprocal products for y / 100 and (y - 1) / 100
    logic        r_a_valid;
    logic [13:0] r_a_year;
    logic [13:0] r_a_pyear;
    logic [3:0]  r_a_month;
    logic [4:0]  r_a_day;
    logic [26:0] r_a_yprod;
    logic [26:0] r_a_pprod;

    logic [13:0] n_a_pyear;

    // stage B
    logic         r_b_valid;
    iwd_pkg::t_s2 r_b;
    iwd_pkg::t_s2 n_b;

    logic ready_a;
    logic ready_b;

    logic [7:0]  q_y;
    logic [7:0]  q_p;
    logic [13:0] rem_y_full;
    logic [13:0] rem_p_full;
    logic [6:0]  rem_y;
    logic [6:0]  rem_p;
    logic [2:0]  c1;
    logic        m_ok;

    assign ready_b = !r_b_valid || i_ready;
    assign ready_a = !r_a_valid || ready_b;
    assign o_ready = ready_a;
    assign o_valid = r_b_valid;
    assign o_s2    = r_b;

    // year zero looks back on a year that behaves like 399
    assign n_a_pyear = (i_year == 14'd0) ? iwd_pkg::PREV_OF_ZERO : i_year - 14'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (ready_a) begin
                r_a_valid <= i_valid;
            end
            if (ready_b) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_a && i_valid) begin
            r_a_year  <= i_year;
            r_a_pyear <= n_a_pyear;
            r_a_month <= i_month;
            r_a_day   <= i_day;
            r_a_yprod <= 27'(i_year) * 27'(iwd_pkg::DIV100_MUL);
            r_a_pprod <= 27'(n_a_pyear) * 27'(iwd_pkg::DIV100_MUL);
        end
        if (ready_b && r_a_valid) begin
            r_b <= n_b;
        end
    end

    always_comb begin
        q_y        = r_a_yprod[iwd_pkg::DIV100_SHIFT +: 8];
        q_p        = r_a_pprod[iwd_pkg::DIV100_SHIFT +: 8];
        rem_y_full = r_a_year - 14'(q_y) * 14'd100;
        rem_p_full = r_a_pyear - 14'(q_p) * 14'd100;
        rem_y      = rem_y_full[6:0];
        rem_p      = rem_p_full[6:0];
        c1         = 3'd6 - {q_y[1:0], 1'b0};
        m_ok       = (r_a_month >= 4'd1) && (r_a_month <= 4'd12);

        n_b.year      = r_a_year;
        n_b.leap      = iwd_pkg::leap_of(r_a_year[1:0], rem_y, q_y[1:0]);
        n_b.leap_prev = iwd_pkg::leap_of(r_a_pyear[1:0], rem_p, q_p[1:0]);
        n_b.mlen      = iwd_pkg::month_len(r_a_month)
                      + 5'((r_a_month == 4'd2) && n_b.leap);
        n_b.ok        = m_ok && (r_a_day != 5'd0) && (r_a_day <= n_b.mlen);
        n_b.doy       = iwd_pkg::days_before(n_b.leap, r_a_month) + 9'(r_a_day) - 9'd1;
        n_b.wsum      = 8'(c1) + 8'(rem_y) + 8'(iwd_pkg::month_anchor(n_b.leap, r_a_month))
                      + 8'(rem_y[6:2]) + 8'(r_a_day);
        n_b.jsum      = 8'(c1) + 8'(rem_y) + (n_b.leap ? 8'd6 : 8'd0)
                      + 8'(rem_y[6:2]) + 8'd1;
    end

    `IWD_ASSERT_IMPL(a_no_leap_pair, r_b_valid, !(r_b.leap && r_b.leap_prev), "two leap years in a row")
    `IWD_ASSERT_NEXT(a_stage_b_load, r_a_valid && ready_b, r_b_valid, "stage B dropped a beat")

endmodule

// ===== rtl/iwd_wday.sv =====
`include "iso_week_date_calc_defines.svh"

module iwd_wday (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  iwd_pkg::t_s2     i_s2,
    output logic             o_valid,
    input  logic             i_ready,
    output iwd_pkg::t_s3     o_s3
);

    logic         r_valid;
    iwd_pkg::t_s3 r_s3;
    iwd_pkg::t_s3 n_s3;
    logic         ready;

    assign ready   = !r_valid || i_ready;
    assign o_ready = ready;
    assign o_valid = r_valid;
    assign o_s3    = r_s3;

    always_comb begin
        n_s3.ok        = i_s2.ok;
        n_s3.leap      = i_s2.leap;
        n_s3.leap_prev = i_s2.leap_prev;
        n_s3.mlen      = i_s2.mlen;
        n_s3.doy       = i_s2.doy;
        n_s3.year      = i_s2.year;
        n_s3.wd        = iwd_pkg::iso_wd(i_s2.wsum);
        n_s3.jan1      = iwd_pkg::iso_wd(i_s2.jsum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready && i_valid) begin
            r_s3 <= n_s3;
        end
    end

    `IWD_ASSERT_IMPL(a_wd_range, r_valid, (r_s3.wd != 3'd0) && (r_s3.jan1 != 3'd0), "weekday out of range")

endmodule

// ===== rtl/iwd_week.sv =====
`include "iso_week_date_calc_defines.svh"

module iwd_week (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  iwd_pkg::t_s3     i_s3,
    output logic             o_valid,
    input  logic             i_stall,
    output logic             o_date_ok,
    output logic             o_leap,
    output logic [4:0]       o_month_days,
    output logic [8:0]       o_year_day,
    output logic [2:0]       o_weekday,
    output logic [5:0]       o_iso_week,
    output logic [13:0]      o_iso_year
);

    logic        r_valid;
    logic        r_date_ok;
    logic        r_leap;
    logic [4:0]  r_month_days;
    logic [8:0]  r_year_day;
    logic [2:0]  r_weekday;
    logic [5:0]  r_iso_week;
    logic [13:0] r_iso_year;

    logic [5:0]  n_iso_week;
    logic [13:0] n_iso_year;

    logic        ready;
    logic [8:0]  n1;
    logic [8:0]  ylen;
    logic [9:0]  num;
    logic [6:0]  wk;
    logic        late_jan1;
    logic        in_prev;
    logic        in_next;

    assign ready   = !r_valid || !i_stall;
    assign o_ready = ready;

    always_comb begin
        n1        = i_s3.doy + 9'd1;
        ylen      = 9'd365 + 9'(i_s3.leap);
        late_jan1 = i_s3.jan1 > 3'd4;
        num       = 10'(n1) + 10'(i_s3.jan1) + 10'd6 - 10'(i_s3.wd);
        wk        = iwd_pkg::div7(num[8:0]) - 7'(late_jan1);
        // first days before the Monday of week 1 belong to last year
        in_prev   = late_jan1 && (n1 <= 9'(4'd8 - 4'(i_s3.jan1)));
        // last days from the Monday of next year's week 1
        in_next   = (i_s3.wd < 3'd4) && ((ylen - n1) < 9'(3'd4 - i_s3.wd));
        if (in_prev) begin
            n_iso_year = i_s3.year - 14'd1;
            n_iso_week = ((i_s3.jan1 == 3'd5) || (i_s3.leap_prev && (i_s3.jan1 == 3'd6)))
                       ? 6'd53 : 6'd52;
        end else if (in_next) begin
            n_iso_year = i_s3.year + 14'd1;
            n_iso_week = 6'd1;
        end else begin
            n_iso_year = i_s3.year;
            n_iso_week = wk[5:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready && i_valid) begin
            r_date_ok    <= i_s3.ok;
            r_leap       <= i_s3.ok && i_s3.leap;
            r_month_days <= i_s3.ok ? i_s3.mlen : 5'd0;
            r_year_day   <= i_s3.ok ? i_s3.doy : 9'd0;
            r_weekday    <= i_s3.ok ? i_s3.wd : 3'd0;
            r_iso_week   <= i_s3.ok ? n_iso_week : 6'd0;
            r_iso_year   <= i_s3.ok ? n_iso_year : 14'd0;
        end
    end

    assign o_valid      = r_valid;
    assign o_date_ok    = r_date_ok;
    assign o_leap       = r_leap;
    assign o_month_days = r_month_days;
    assign o_year_day   = r_year_day;
    assign o_weekday    = r_weekday;
    assign o_iso_week   = r_iso_week;
    assign o_iso_year   = r_iso_year;

    `IWD_ASSERT_IMPL(a_week_range, o_valid && o_date_ok, (o_iso_week != 6'd0) && (o_iso_week <= 6'd53) && (o_weekday != 3'd0), "week or weekday out of range")
    `IWD_ASSERT_IMPL(a_bad_zero, o_valid && !o_date_ok, (o_iso_week == 6'd0) && (o_iso_year == 14'd0) && (o_weekday == 3'd0) && !o_leap, "invalid date not zeroed")

endmodule

// ===== rtl/iso_week_date_calc.sv =====
// ISO week date from a Gregorian date, four register stages.
// Throughput: one beat per cycle while i_stall is low; a full stage
// holds while the next stage cannot take its beat and refills as soon
// as it drains.
// Reset (i_rst_n low, synchronous) clears all stage valid bits; data
// registers are not reset.
module iso_week_date_calc (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [13:0] i_year,
    input  logic [3:0]  i_month,
    input  logic [4:0]  i_day,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_date_ok,
    output logic        o_leap,
    output logic [4:0]  o_month_days,
    output logic [8:0]  o_year_day,
    output logic [2:0]  o_weekday,
    output logic [5:0]  o_iso_week,
    output logic [13:0] o_iso_year
);

    logic         year_ready;
    logic         s2_valid;
    logic         wday_ready;
    iwd_pkg::t_s2 s2;
    logic         s3_valid;
    logic         week_ready;
    iwd_pkg::t_s3 s3;

    assign o_stall = !year_ready;

    iwd_year u_year (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (year_ready),
        .i_year  (i_year),
        .i_month (i_month),
        .i_day   (i_day),
        .o_valid (s2_valid),
        .i_ready (wday_ready),
        .o_s2    (s2)
    );

    iwd_wday u_wday (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_ready (wday_ready),
        .i_s2    (s2),
        .o_valid (s3_valid),
        .i_ready (week_ready),
        .o_s3    (s3)
    );

    iwd_week u_week (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s3_valid),
        .o_ready      (week_ready),
        .i_s3         (s3),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_date_ok    (o_date_ok),
        .o_leap       (o_leap),
        .o_month_days (o_month_days),
        .o_year_day   (o_year_day),
        .o_weekday    (o_weekday),
        .o_iso_week   (o_iso_week),
        .o_iso_year   (o_iso_year)
    );

endmodule

// ===== tb/sv/tb_iso_week_date_calc.sv =====
`timescale 1ns / 1ps

module tb_iso_week_date_calc;

    localparam int HANG_LIMIT = 2000;   // cycles with no beat on either side
    localparam int HOLD_CYCLES = 300;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic        date_ok;
        logic        leap;
        logic [4:0]  month_days;
        logic [8:0]  year_day;
        logic [2:0]  weekday;
        logic [5:0]  week_no;
        logic [13:0] week_year;
    } week_date_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [13:0] i_year;
    logic [3:0]  i_month;
    logic [4:0]  i_day;
    logic        o_valid;
    logic        i_stall;
    logic        o_date_ok;
    logic        o_leap;
    logic [4:0]  o_month_days;
    logic [8:0]  o_year_day;
    logic [2:0]  o_weekday;
    logic [5:0]  o_iso_week;
    logic [13:0] o_iso_year;

    // weekday anchors and days before each month, indexed by month 1..12; month lengths by month - 1
    int unsigned anchor_common[13] = '{0, 0, 3, 3, 6, 1, 4, 6, 2, 5, 0, 3, 5};
    int unsigned anchor_leap[13]   = '{0, 6, 2, 3, 6, 1, 4, 6, 2, 5, 0, 3, 5};
    int unsigned days_common[13]   = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
    int unsigned days_leap[13]     = '{0, 0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335};
    int unsigned len_common[12]    = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    week_date_t expected_dates[$];
    week_date_t got_date;
    week_date_t want_date;
    int         fail_count = 0;
    int         idle_cycles = 0;
    int         hold_left = 0;
    int         stall_run = 0;
    int         stall_pick;
    bit         sender_gaps_on = 1'b0;
    bit         rcv_stalls_on = 1'b0;

    iso_week_date_calc u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_year       (i_year),
        .i_month      (i_month),
        .i_day        (i_day),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_date_ok    (o_date_ok),
        .o_leap       (o_leap),
        .o_month_days (o_month_days),
        .o_year_day   (o_year_day),
        .o_weekday    (o_weekday),
        .o_iso_week   (o_iso_week),
        .o_iso_year   (o_iso_year)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic bit leap_year(int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned days_in_month(int unsigned y, int unsigned m);
        return len_common[m - 1] + ((m == 2 && leap_year(y)) ? 1 : 0);
    endfunction

    // century / year / month table formula, 1 Monday .. 7 Sunday
    function automatic int unsigned wday_of(int unsigned y, int unsigned m,
                                            int unsigned d);
        int unsigned cent_term, yy, anchor, s;
        cent_term = 6 - 2 * ((y / 100) % 4);
        yy = y % 100;
        anchor = leap_year(y) ? anchor_leap[m] : anchor_common[m];
        s = (cent_term + yy + anchor + yy / 4 + d) % 7;
        return (s == 0) ? 7 : s;
    endfunction

    function automatic week_date_t predict_week_date(logic [13:0] y14, logic [3:0] m4,
                                                     logic [4:0] d5);
        week_date_t  r;
        int unsigned y, m, d, lp, mlen, doy, wd, jan1, n, ylen, prev, week, iy;
        r = '0;
        y = 32'(y14);
        m = 32'(m4);
        d = 32'(d5);
        if (m < 1 || m > 12) begin
            return r;
        end
        lp = leap_year(y);
        mlen = days_in_month(y, m);
        if (d < 1 || d > mlen) begin
            return r;
        end
        doy = (lp ? days_leap[m] : days_common[m]) + d - 1;
        wd = wday_of(y, m, d);
        jan1 = wday_of(y, 1, 1);
        n = doy + 1;
        ylen = 365 + lp;
        if (jan1 > 4 && n <= 8 - jan1) begin
            // early January still in the last week of the previous year
            prev = (y == 0) ? 399 : y - 1;
            iy = (y + 16383) % 16384;
            week = (jan1 == 5 || (leap_year(prev) && jan1 == 6)) ? 53 : 52;
        end else if (wd < 4 && ylen - n < 4 - wd) begin
            // late December already in week 1 of the next year
            iy = (y + 1) % 16384;
            week = 1;
        end else begin
            iy = y;
            week = (n + (7 - wd) + (jan1 - 1)) / 7;
            if (jan1 > 4) begin
                week = week - 1;
            end
        end
        r.date_ok = 1'b1;
        r.leap = lp[0];
        r.month_days = mlen[4:0];
        r.year_day = doy[8:0];
        r.weekday = wd[2:0];
        r.week_no = week[5:0];
        r.week_year = iy[13:0];
        return r;
    endfunction

    function automatic int gap_len();
        int r;
        if (!sender_gaps_on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 40);
    endfunction

    // one input beat; returns at the edge that accepts it
    task automatic send_date(input logic [13:0] y, input logic [3:0] m, input logic [4:0] d);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_year <= y;
        i_month <= m;
        i_day <= d;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_dates.push_back(predict_week_date(y, m, d));
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_dates.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_random_date();
        int         pick;
        logic [13:0] y;
        logic [3:0]  m;
        logic [4:0]  d;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            {y, m, d} = 23'($urandom);
        end else begin
            y = (pick < 22) ? 14'($urandom) : 14'($urandom_range(1, 9999));
            m = 4'($urandom_range(1, 12));
            if (pick < 50) begin
                // around the turn of the year, where the week-year differs
                if ($urandom_range(0, 1) == 1) begin
                    m = 4'd1;
                    d = 5'($urandom_range(1, 7));
                end else begin
                    m = 4'd12;
                    d = 5'($urandom_range(25, 31));
                end
            end else if (pick < 55) begin
                d = (pick < 53) ? 5'(days_in_month(y, m) + 1) : 5'd0;
                if (d == 5'd0 || days_in_month(y, m) == 31) begin
                    d = 5'($urandom_range(0, 1) ? 0 : 31);
                end
            end else begin
                d = 5'($urandom_range(1, days_in_month(y, m)));
            end
        end
        send_date(y, m, d);
    endtask

    task automatic test_directed_dates();
        sender_gaps_on = 1'b0;
        rcv_stalls_on = 1'b0;
        send_date(14'd1, 4'd1, 5'd1);
        send_date(14'd9999, 4'd12, 5'd31);
        send_date(14'd16383, 4'd12, 5'd29);
        send_date(14'd16383, 4'd12, 5'd30);
        send_date(14'd16383, 4'd12, 5'd31);
        send_date(14'd0, 4'd1, 5'd1);      // year zero, week-year wraps back
        send_date(14'd0, 4'd12, 5'd31);
        send_date(14'd2000, 4'd2, 5'd29);
        send_date(14'd1900, 4'd2, 5'd29);  // not leap: bad day
        send_date(14'd2004, 4'd2, 5'd29);
        send_date(14'd2023, 4'd0, 5'd10);  // bad months
        send_date(14'd2023, 4'd13, 5'd10);
        send_date(14'd2023, 4'd15, 5'd31);
        send_date(14'd2023, 4'd5, 5'd0);
        send_date(14'd2023, 4'd4, 5'd31);
        send_date(14'd2023, 4'd3, 5'd31);
        send_date(14'd2021, 4'd1, 5'd1);   // Friday Jan 1: week 53 of prior year
        send_date(14'd2020, 4'd12, 5'd31);
        send_date(14'd2019, 4'd12, 5'd30); // week 1 of next year
        send_date(14'd2017, 4'd1, 5'd1);   // Sunday, prior year leap: week 52
        send_date(14'd2022, 4'd1, 5'd1);   // Saturday, prior year common
        send_date(14'd2005, 4'd1, 5'd1);   // Saturday, prior year leap: week 53
        send_date(14'd2026, 4'd1, 5'd4);
        end_burst();
        wait_drained();
    endtask

    // receiver holds off while the sender keeps offering beats back to back
    task automatic test_full_pipeline();
        sender_gaps_on = 1'b0;
        rcv_stalls_on = 1'b0;
        hold_left = HOLD_CYCLES;
        repeat (60) send_random_date();
        end_burst();
        wait_drained();
    endtask

    task automatic test_drain_pause();
        sender_gaps_on = 1'b1;
        rcv_stalls_on = 1'b1;
        repeat (5) begin
            repeat (20) send_random_date();
            end_burst();
            wait_drained();
        end
    endtask

    task automatic test_random_dates();
        int k;
        for (k = 0; k < 1270; k++) begin
            if (k % 100 == 0) begin
                sender_gaps_on = ($urandom_range(0, 3) != 0);
                rcv_stalls_on = ($urandom_range(0, 3) != 0);
            end
            send_random_date();
        end
        end_burst();
    endtask

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else if (!rcv_stalls_on) begin
            i_stall <= 1'b0;
            stall_run = 0;
        end else if (stall_run > 0) begin
            stall_run = stall_run - 1;
        end else begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 60) begin
                i_stall <= 1'b0;
                stall_run = $urandom_range(0, 6);
            end else if (stall_pick < 92) begin
                i_stall <= 1'b1;
                stall_run = $urandom_range(0, 2);
            end else begin
                i_stall <= 1'b1;
                stall_run = $urandom_range(5, 40);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            got_date = {o_date_ok, o_leap, o_month_days, o_year_day,
                        o_weekday, o_iso_week, o_iso_year};
            if (expected_dates.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX) begin
                    $display("result beat with nothing expected: ok=%0d week=%0d year=%0d",
                             o_date_ok, o_iso_week, o_iso_year);
                end
            end else begin
                want_date = expected_dates.pop_front();
                if (got_date !== want_date) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX) begin
                        $display("mismatch: ok %0d/%0d leap %0d/%0d mdays %0d/%0d yday %0d/%0d",
                                 want_date.date_ok, got_date.date_ok,
                                 want_date.leap, got_date.leap,
                                 want_date.month_days, got_date.month_days,
                                 want_date.year_day, got_date.year_day);
                        $display("          wday %0d/%0d week %0d/%0d wyear %0d/%0d",
                                 want_date.weekday, got_date.weekday,
                                 want_date.week_no, got_date.week_no,
                                 want_date.week_year, got_date.week_year);
                    end
                end
            end
        end
    end

    // hang detector: counts cycles with no beat on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= HANG_LIMIT) begin
            $display("timeout: no beat for %0d cycles", HANG_LIMIT);
            $display("tb_iso_week_date_calc: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_year = '0;
        i_month = '0;
        i_day = '0;
        i_stall = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_dates();
        test_full_pipeline();
        test_drain_pause();
        test_random_dates();

        wait_drained();
        repeat (12) @(posedge i_clk);
        if (expected_dates.size() != 0) begin
            fail_count += expected_dates.size();
            $display("%0d expected results never arrived", expected_dates.size());
        end
        if (fail_count == 0) begin
            $display("tb_iso_week_date_calc: done, clean");
        end else begin
            $display("tb_iso_week_date_calc: done, errors");
        end
        $finish;
    end

endmodule
